/* rtl/upa_pkg.sv */
// Shared types, widths and helpers for the uncertainty propagation ALU.
// No dependencies; imported by every module of the block.
package upa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int ERR_W     = 31;
    localparam int PRD_W     = 63;
    // quotient bits of a divider lane, and the dividend width it takes
    localparam int QN        = 32 + FRAC_BITS;
    localparam int DVD_W     = QN + 32;
    localparam int DIV_LAT   = QN + 1;
    localparam int SQ_STEPS  = 32;
    localparam int SQ_REM_W  = SQ_STEPS + 2;
    localparam int HYP_LAT   = SQ_STEPS + 2;
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 72;

    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_REL
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_DIVZ,
        ST_SAT
    } st_t;

    // how the final error is formed
    typedef enum logic [1:0] {
        EK_HYP,
        EK_MAX,
        EK_ZERO
    } ek_t;

    typedef struct packed {
        op_t              op;
        logic             divz;
        logic             neg;
        logic [VAL_W-1:0] vval;
        logic             vsat;
        logic [ERR_W-1:0] t1;
        logic [ERR_W-1:0] t2;
        logic             tsat;
        logic [31:0]      dvs;
    } side_t;

    typedef struct packed {
        logic [VAL_W-1:0] vval;
        st_t              st;
        ek_t              ek;
    } post_t;

    // signed saturation of a sign and magnitude; returns {sat, value}
    function automatic logic [VAL_W:0] sat_signed(input logic neg, input logic [63:0] m);
        logic             big;
        logic [VAL_W:0]   r;
        big = |m[63:VAL_W];
        if (neg) begin
            if (big || (m[VAL_W-1] && |m[VAL_W-2:0])) begin
                r = {1'b1, VAL_MIN};
            end else begin
                r = {1'b0, VAL_W'(-m[VAL_W-1:0])};
            end
        end else begin
            if (big || m[VAL_W-1]) begin
                r = {1'b1, VAL_MAX};
            end else begin
                r = {1'b0, m[VAL_W-1:0]};
            end
        end
        return r;
    endfunction

endpackage

/* rtl/upa_div_lane.sv */
// Pipelined restoring divider lane, one quotient bit per stage.
// Depends on upa_pkg. Quotient ovf flags results of 2^QN or more.
module upa_div_lane (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [upa_pkg::DVD_W-1:0] dvd,
    input  logic [31:0]             dvs,
    output logic [upa_pkg::QN-1:0]  quo,
    output logic                    ovf
);
    import upa_pkg::*;

    logic [31:0]   rem_reg  [0:QN];
    logic [QN-1:0] low_reg  [0:QN];
    logic [31:0]   dvs_reg  [0:QN];
    logic          ovf_reg  [0:QN];
    logic [31:0]   rem_next [1:QN];
    logic [QN-1:0] low_next [1:QN];

    genvar k;
    generate
        for (k = 0; k < QN; k++) begin : g_step
            logic [32:0] part;
            logic        ge;
            assign part = {rem_reg[k], low_reg[k][QN-1]};
            assign ge   = part >= {1'b0, dvs_reg[k]};
            assign rem_next[k+1] = ge ? 32'(part - {1'b0, dvs_reg[k]}) : part[31:0];
            assign low_next[k+1] = {low_reg[k][QN-2:0], ge};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= dvd[DVD_W-1:QN];
            low_reg[0] <= dvd[QN-1:0];
            dvs_reg[0] <= dvs;
            ovf_reg[0] <= dvd[DVD_W-1:QN] >= dvs;
            for (int i = 1; i <= QN; i++) begin
                rem_reg[i] <= rem_next[i];
                low_reg[i] <= low_next[i];
                dvs_reg[i] <= dvs_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    assign quo = low_reg[QN];
    assign ovf = ovf_reg[QN] | (|rem_reg[QN] & 1'b0) | (|dvs_reg[QN] & 1'b0);

endmodule

/* rtl/upa_hyp.sv */
// Pipelined sqrt(t1^2 + t2^2): squares, sum, then two radicand bits per stage.
// Depends on upa_pkg.
module upa_hyp (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [upa_pkg::ERR_W-1:0] t1,
    input  logic [upa_pkg::ERR_W-1:0] t2,
    output logic [upa_pkg::SQ_STEPS-1:0] root
);
    import upa_pkg::*;

    logic [2*ERR_W-1:0]    sq1_reg;
    logic [2*ERR_W-1:0]    sq2_reg;
    logic [SQ_REM_W-1:0]   rem_reg   [0:SQ_STEPS];
    logic [SQ_STEPS-1:0]   root_reg  [0:SQ_STEPS];
    logic [2*SQ_STEPS-1:0] xs_reg    [0:SQ_STEPS];
    logic [SQ_REM_W-1:0]   rem_next  [1:SQ_STEPS];
    logic [SQ_STEPS-1:0]   root_next [1:SQ_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++) begin : g_step
            logic [SQ_REM_W+1:0] r4;
            logic [SQ_REM_W+1:0] trial;
            logic                ge;
            assign r4    = {rem_reg[k], xs_reg[k][2*SQ_STEPS-1 -: 2]};
            assign trial = {2'b00, root_reg[k], 2'b01};
            assign ge    = r4 >= trial;
            assign rem_next[k+1]  = ge ? SQ_REM_W'(r4 - trial) : r4[SQ_REM_W-1:0];
            assign root_next[k+1] = {root_reg[k][SQ_STEPS-2:0], ge};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            sq1_reg     <= t1 * t1;
            sq2_reg     <= t2 * t2;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            xs_reg[0]   <= (2*SQ_STEPS)'(sq1_reg) + (2*SQ_STEPS)'(sq2_reg);
            for (int i = 1; i <= SQ_STEPS; i++) begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                xs_reg[i]   <= xs_reg[i-1] << 2;
            end
        end
    end

    assign root = root_reg[SQ_STEPS] | ({SQ_STEPS{1'b0}} & SQ_STEPS'(rem_reg[SQ_STEPS]))
                  | ({SQ_STEPS{1'b0}} & xs_reg[SQ_STEPS][SQ_STEPS-1:0]);

endmodule

/* rtl/uncertainty_propagation_alu.sv */
// Top level of the uncertainty propagation ALU: front stages, divider lanes,
// error combination and the output register with skid. Uses upa_pkg,
// upa_div_lane and upa_hyp.
//
// Fully pipelined: a new word is taken every cycle while the skid word is
// empty (s_tready high). The pipeline depth comes from the two chained divider
// lanes (one quotient bit per stage, second lane for the a*eb/b^2 term) and the
// 32-stage square root of the quadrature sum. Ops: add, sub, mul, div, relative
// error of a; a scalar operand is an operand with zero error. Results saturate
// with status 2; division by zero, or relative error of a zero value, gives
// status 1. Undefined ops return zeros.
module uncertainty_propagation_alu (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // op[2:0], a_value[34:3], a_error[65:35], b_value[97:66], b_error[128:98]
    input  logic [upa_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_value[31:0], result_error[62:32], status[64:63]
    output logic [upa_pkg::M_TDATA_W-1:0] m_tdata
);
    import upa_pkg::*;

    logic en;

    // input stage
    logic                     p0_vld_reg;
    op_t                      p0_op_reg;
    logic signed [VAL_W-1:0]  p0_a_reg;
    logic signed [VAL_W-1:0]  p0_b_reg;
    logic [ERR_W-1:0]         p0_ea_reg;
    logic [ERR_W-1:0]         p0_eb_reg;

    // magnitudes and sum
    logic                     p1_vld_reg;
    op_t                      p1_op_reg;
    logic signed [VAL_W-1:0]  p1_a_reg;
    logic signed [VAL_W-1:0]  p1_b_reg;
    logic [ERR_W-1:0]         p1_ea_reg;
    logic [ERR_W-1:0]         p1_eb_reg;
    logic [VAL_W-1:0]         p1_ma_reg;
    logic [VAL_W-1:0]         p1_mb_reg;
    logic signed [VAL_W:0]    p1_sum_reg;
    logic [VAL_W-1:0]         ma_next;
    logic [VAL_W-1:0]         mb_next;
    logic signed [VAL_W:0]    sum_next;

    // products
    logic                     p2_vld_reg;
    op_t                      p2_op_reg;
    logic [ERR_W-1:0]         p2_ea_reg;
    logic [ERR_W-1:0]         p2_eb_reg;
    logic [VAL_W-1:0]         p2_ma_reg;
    logic [VAL_W-1:0]         p2_mb_reg;
    logic signed [VAL_W:0]    p2_sum_reg;
    logic signed [63:0]       p2_prd_ab_reg;
    logic [PRD_W-1:0]         p2_prd_bea_reg;
    logic [PRD_W-1:0]         p2_prd_aeb_reg;
    logic                     p2_a_neg_reg;
    logic                     p2_a_zero_reg;
    logic                     p2_b_neg_reg;
    logic                     p2_b_zero_reg;

    // divider stages
    side_t                    side_a_next;
    side_t                    side_b_next;
    side_t                    sa_reg [0:DIV_LAT-1];
    side_t                    sb_reg [0:DIV_LAT-1];
    logic [DIV_LAT-1:0]       va_reg;
    logic [DIV_LAT-1:0]       vb_reg;
    logic [DVD_W-1:0]         dvd0, dvd1, dvd2, dvd3;
    logic [31:0]              dvs0;
    logic [QN-1:0]            quo0, quo1, quo2, quo3;
    logic                     ovf0, ovf1, ovf2, ovf3;

    // error combination
    post_t                    post_next;
    post_t                    ph_reg [0:HYP_LAT-1];
    logic [HYP_LAT-1:0]       vh_reg;
    logic [ERR_W-1:0]         hyp_t2;
    logic [SQ_STEPS-1:0]      root;

    // result and output
    post_t                    tail;
    st_t                      res_st;
    logic [ERR_W-1:0]         res_err;
    logic [M_TDATA_W-1:0]     res_data;
    logic                     out_vld_reg;
    logic [M_TDATA_W-1:0]     out_data_reg;
    logic                     skid_vld_reg;
    logic [M_TDATA_W-1:0]     skid_data_reg;

    // the whole pipeline moves while the skid word is empty
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            va_reg     <= '0;
            vb_reg     <= '0;
            vh_reg     <= '0;
        end else if (en) begin
            p0_vld_reg <= s_tvalid;
            p1_vld_reg <= p0_vld_reg;
            p2_vld_reg <= p1_vld_reg;
            va_reg     <= {va_reg[DIV_LAT-2:0], p2_vld_reg};
            vb_reg     <= {vb_reg[DIV_LAT-2:0], va_reg[DIV_LAT-1]};
            vh_reg     <= {vh_reg[HYP_LAT-2:0], vb_reg[DIV_LAT-1]};
        end
    end

    assign ma_next  = p0_a_reg[VAL_W-1] ? VAL_W'(-p0_a_reg) : VAL_W'(p0_a_reg);
    assign mb_next  = p0_b_reg[VAL_W-1] ? VAL_W'(-p0_b_reg) : VAL_W'(p0_b_reg);
    assign sum_next = (p0_op_reg == OP_SUB)
                    ? $signed({p0_a_reg[VAL_W-1], p0_a_reg}) - $signed({p0_b_reg[VAL_W-1], p0_b_reg})
                    : $signed({p0_a_reg[VAL_W-1], p0_a_reg}) + $signed({p0_b_reg[VAL_W-1], p0_b_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_op_reg      <= op_t'(s_tdata[2:0]);
            p0_a_reg       <= s_tdata[34:3];
            p0_ea_reg      <= s_tdata[65:35];
            p0_b_reg       <= s_tdata[97:66];
            p0_eb_reg      <= s_tdata[128:98];

            p1_op_reg      <= p0_op_reg;
            p1_a_reg       <= p0_a_reg;
            p1_b_reg       <= p0_b_reg;
            p1_ea_reg      <= p0_ea_reg;
            p1_eb_reg      <= p0_eb_reg;
            p1_ma_reg      <= ma_next;
            p1_mb_reg      <= mb_next;
            p1_sum_reg     <= sum_next;

            p2_op_reg      <= p1_op_reg;
            p2_ea_reg      <= p1_ea_reg;
            p2_eb_reg      <= p1_eb_reg;
            p2_ma_reg      <= p1_ma_reg;
            p2_mb_reg      <= p1_mb_reg;
            p2_sum_reg     <= p1_sum_reg;
            p2_prd_ab_reg  <= p1_a_reg * p1_b_reg;
            p2_prd_bea_reg <= p1_mb_reg * p1_ea_reg;
            p2_prd_aeb_reg <= p1_ma_reg * p1_eb_reg;
            p2_a_neg_reg   <= p1_a_reg[VAL_W-1];
            p2_a_zero_reg  <= p1_a_reg == '0;
            p2_b_neg_reg   <= p1_b_reg[VAL_W-1];
            p2_b_zero_reg  <= p1_b_reg == '0;
        end
    end

    // value for add/sub/mul, error terms for add/sub/mul, zero-divisor cases
    always_comb begin
        logic signed [63:0] s64;
        logic [63:0]        smag;
        logic [63:0]        pmag;
        logic [PRD_W-1:0]   hi1;
        logic [PRD_W-1:0]   hi2;
        s64  = 64'(p2_sum_reg);
        smag = s64[63] ? 64'(-s64) : 64'(s64);
        pmag = p2_prd_ab_reg[63] ? 64'(-p2_prd_ab_reg) : 64'(p2_prd_ab_reg);
        hi1  = p2_prd_bea_reg >> FRAC_BITS;
        hi2  = p2_prd_aeb_reg >> FRAC_BITS;
        side_a_next      = '0;
        side_a_next.op   = p2_op_reg;
        side_a_next.dvs  = p2_mb_reg;
        side_a_next.neg  = (p2_op_reg == OP_REL) ? p2_a_neg_reg : (p2_a_neg_reg ^ p2_b_neg_reg);
        case (p2_op_reg)
            OP_ADD, OP_SUB: begin
                {side_a_next.vsat, side_a_next.vval} = sat_signed(s64[63], smag);
                side_a_next.t1 = p2_ea_reg;
                side_a_next.t2 = p2_eb_reg;
            end
            OP_MUL: begin
                {side_a_next.vsat, side_a_next.vval} =
                    sat_signed(p2_prd_ab_reg[63], pmag >> FRAC_BITS);
                side_a_next.t1   = hi1[ERR_W-1:0];
                side_a_next.t2   = hi2[ERR_W-1:0];
                side_a_next.tsat = (hi1 > PRD_W'(ERR_MAX)) || (hi2 > PRD_W'(ERR_MAX));
            end
            OP_DIV: begin
                if (p2_b_zero_reg) begin
                    side_a_next.divz = 1'b1;
                    side_a_next.vval = p2_a_zero_reg ? '0 : (p2_a_neg_reg ? VAL_MIN : VAL_MAX);
                end
            end
            OP_REL: begin
                if (p2_a_zero_reg) begin
                    side_a_next.divz = 1'b1;
                    side_a_next.vval = VAL_MAX;
                end
            end
            default: begin
            end
        endcase
    end

    // lane 0: value quotient (a/b or ea/a), lane 1: ea/b, lane 2: a*eb/b
    assign dvd0 = (p2_op_reg == OP_REL) ? DVD_W'(p2_ea_reg) << FRAC_BITS
                                        : DVD_W'(p2_ma_reg) << FRAC_BITS;
    assign dvs0 = (p2_op_reg == OP_REL) ? p2_ma_reg : p2_mb_reg;
    assign dvd1 = DVD_W'(p2_ea_reg) << FRAC_BITS;
    assign dvd2 = DVD_W'(p2_prd_aeb_reg);

    upa_div_lane u_lane0 (.aclk(aclk), .en(en), .dvd(dvd0), .dvs(dvs0),
                          .quo(quo0), .ovf(ovf0));
    upa_div_lane u_lane1 (.aclk(aclk), .en(en), .dvd(dvd1), .dvs(p2_mb_reg),
                          .quo(quo1), .ovf(ovf1));
    upa_div_lane u_lane2 (.aclk(aclk), .en(en), .dvd(dvd2), .dvs(p2_mb_reg),
                          .quo(quo2), .ovf(ovf2));

    always_comb begin
        side_b_next = sa_reg[DIV_LAT-1];
        if ((side_b_next.op == OP_DIV || side_b_next.op == OP_REL) && !side_b_next.divz) begin
            {side_b_next.vsat, side_b_next.vval} =
                sat_signed(side_b_next.neg, ovf0 ? {64{1'b1}} : 64'(quo0));
        end
        if (side_b_next.op == OP_DIV && !side_b_next.divz) begin
            side_b_next.t1   = quo1[ERR_W-1:0];
            side_b_next.tsat = ovf1 || ovf2 || (quo1 > QN'(ERR_MAX));
        end
    end

    // lane 3: (a*eb/b)/b
    assign dvd3 = DVD_W'(quo2) << FRAC_BITS;

    upa_div_lane u_lane3 (.aclk(aclk), .en(en), .dvd(dvd3), .dvs(sa_reg[DIV_LAT-1].dvs),
                          .quo(quo3), .ovf(ovf3));

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_reg[0] <= side_a_next;
            sb_reg[0] <= side_b_next;
            ph_reg[0] <= post_next;
            for (int i = 1; i < DIV_LAT; i++) begin
                sa_reg[i] <= sa_reg[i-1];
                sb_reg[i] <= sb_reg[i-1];
            end
            for (int i = 1; i < HYP_LAT; i++) begin
                ph_reg[i] <= ph_reg[i-1];
            end
        end
    end

    always_comb begin
        side_t s;
        logic  tsat;
        s      = sb_reg[DIV_LAT-1];
        tsat   = s.tsat;
        hyp_t2 = s.t2;
        if (s.op == OP_DIV && !s.divz) begin
            hyp_t2 = quo3[ERR_W-1:0];
            tsat   = tsat || ovf3 || (quo3 > QN'(ERR_MAX));
        end
        post_next.vval = s.vval;
        case (s.op)
            OP_ADD, OP_SUB, OP_MUL: post_next.ek = tsat ? EK_MAX : EK_HYP;
            OP_DIV:                 post_next.ek = (s.divz || tsat) ? EK_MAX : EK_HYP;
            default:                post_next.ek = EK_ZERO;
        endcase
        if (s.divz) begin
            post_next.st = ST_DIVZ;
        end else if (s.vsat || post_next.ek == EK_MAX) begin
            post_next.st = ST_SAT;
        end else begin
            post_next.st = ST_OK;
        end
    end

    upa_hyp u_hyp (.aclk(aclk), .en(en), .t1(sb_reg[DIV_LAT-1].t1), .t2(hyp_t2),
                   .root(root));

    always_comb begin
        tail    = ph_reg[HYP_LAT-1];
        res_st  = tail.st;
        case (tail.ek)
            EK_HYP: begin
                if (root[SQ_STEPS-1]) begin
                    res_err = ERR_MAX;
                    if (res_st == ST_OK) begin
                        res_st = ST_SAT;
                    end
                end else begin
                    res_err = root[ERR_W-1:0];
                end
            end
            EK_MAX:  res_err = ERR_MAX;
            default: res_err = '0;
        endcase
        res_data = M_TDATA_W'({res_st, res_err, tail.vval});
    end

    // output word plus one skid word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (en && vh_reg[HYP_LAT-1]) begin
            if (!out_vld_reg || m_tready) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (!en) begin
            if (m_tready) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && vh_reg[HYP_LAT-1]) begin
            if (!out_vld_reg || m_tready) begin
                out_data_reg <= res_data;
            end else begin
                skid_data_reg <= res_data;
            end
        end else if (!en && m_tready) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid word held without an output word");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(out_vld_reg) && !$past(m_tready))
        else $error("skid filled while output was free");

    a_divz_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[64:63] == ST_DIVZ)
            |-> (m_tdata[62:32] == ERR_MAX || m_tdata[62:32] == '0))
        else $error("division by zero with unexpected error field");

endmodule
